// ===== src/lqr_pkg.sv =====
// package for the lqr state-feedback pwm unit: payload types, register codes
// and fixed-point constants; no dependencies
package lqr_pkg;

    // fraction bits of positions, angles, rates and gains
    localparam int FRAC_BITS = 16;
    // microseconds per second, velocity scale
    localparam logic [19:0] US_PER_S = 20'd1000000;

    // configuration register indexes
    localparam logic [2:0] REG_GAIN_POS   = 3'd0;
    localparam logic [2:0] REG_GAIN_VEL   = 3'd1;
    localparam logic [2:0] REG_GAIN_ANG   = 3'd2;
    localparam logic [2:0] REG_GAIN_RATE  = 3'd3;
    localparam logic [2:0] REG_MAX_VOLT   = 3'd4;
    localparam logic [2:0] REG_DUTY_BITS  = 3'd5;

    // reset values
    localparam logic [7:0] MAX_VOLT_RST  = 8'd12;
    localparam logic [4:0] DUTY_BITS_RST = 5'd8;

    typedef struct packed {
        logic [23:0]        elapsed_us;
        logic signed [31:0] cart_position;
        logic signed [31:0] cart_delta;
        logic signed [31:0] pendulum_angle;
        logic signed [31:0] angle_delta;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pwm_duty;
        logic        direction;
        logic        saturated;
    } t_out_item;

endpackage

// ===== src/lqr_state_feedback_pwm_unit.sv =====
// top level of the lqr state-feedback pwm unit: rate division, gain sum,
// clamp and duty scaling in one pipeline; depends on lqr_pkg
//
// One item may be started in every clock cycle; o_busy stays low. Each item
// gives one result strobe on o_valid. The depth is set by the two velocity
// dividers (one quotient bit per stage, 32 stages plus an overflow check) and
// the duty divider (16 stages). The receiver cannot stall, so results are
// never held back.
module lqr_state_feedback_pwm_unit
    import lqr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_in_item    i_item,
    output logic        o_busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output t_out_item   o_result
);

    localparam int LAT = 56;

    // configuration registers
    logic signed [31:0] r_gain [0:3];
    logic [7:0]         r_max_voltage;
    logic [4:0]         r_duty_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain[0]     <= '0;
            r_gain[1]     <= '0;
            r_gain[2]     <= '0;
            r_gain[3]     <= '0;
            r_max_voltage <= MAX_VOLT_RST;
            r_duty_bits   <= DUTY_BITS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN_POS:  r_gain[0] <= i_cfg_data;
                REG_GAIN_VEL:  r_gain[1] <= i_cfg_data;
                REG_GAIN_ANG:  r_gain[2] <= i_cfg_data;
                REG_GAIN_RATE: r_gain[3] <= i_cfg_data;
                REG_MAX_VOLT:  r_max_voltage <= i_cfg_data[7:0];
                REG_DUTY_BITS: r_duty_bits <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // stage 0: input capture
    logic     r_v0;
    t_in_item r_in0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_in0 <= i_item;
        end
    end

    // stage 1: magnitude of each delta times 1e6
    logic        r_v1;
    logic [50:0] r_n1 [0:1];
    logic        r_neg1 [0:1];
    logic [23:0] r_d1;
    logic [31:0] r_pos1, r_ang1;
    logic [31:0] w_dmag [0:1];
    logic [51:0] w_prod1 [0:1];
    logic [31:0] w_delta [0:1];

    assign w_delta[0] = r_in0.cart_delta;
    assign w_delta[1] = r_in0.angle_delta;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_dmag[l]  = w_delta[l][31] ? (32'd0 - w_delta[l]) : w_delta[l];
            w_prod1[l] = {20'd0, w_dmag[l]} * {32'd0, US_PER_S};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            r_n1[l]   <= w_prod1[l][50:0];
            r_neg1[l] <= w_delta[l][31];
        end
        r_d1   <= r_in0.elapsed_us;
        r_pos1 <= r_in0.cart_position;
        r_ang1 <= r_in0.pendulum_angle;
    end

    // divider pipeline arrays, index 0 loaded by the overflow check stage
    logic        r_dv   [0:32];
    logic [50:0] r_dn   [0:32][0:1];
    logic [31:0] r_dq   [0:32][0:1];
    logic        r_dneg [0:32][0:1];
    logic        r_dovf [0:32][0:1];
    logic [23:0] r_dd   [0:32];
    logic [31:0] r_dpos [0:32];
    logic [31:0] r_dang [0:32];

    // stage 2: quotient overflow check, n >= d * 2^32
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            r_dn[0][l]   <= r_n1[l];
            r_dq[0][l]   <= '0;
            r_dneg[0][l] <= r_neg1[l];
            r_dovf[0][l] <= ({5'd0, r_n1[l]} >= {r_d1, 32'd0});
        end
        r_dd[0]   <= r_d1;
        r_dpos[0] <= r_pos1;
        r_dang[0] <= r_ang1;
    end

    // velocity divider: one quotient bit per stage, msb first
    for (genvar k = 0; k < 32; k++) begin : g_vdiv
        localparam int SH = 31 - k;
        logic [55:0] w_sub;
        logic        w_ge [0:1];
        logic [55:0] w_dif [0:1];

        assign w_sub = {32'd0, r_dd[k]} << SH;

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                w_ge[l]  = ({5'd0, r_dn[k][l]} >= w_sub);
                w_dif[l] = {5'd0, r_dn[k][l]} - w_sub;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int l = 0; l < 2; l++) begin
                r_dn[k+1][l]   <= w_ge[l] ? w_dif[l][50:0] : r_dn[k][l];
                r_dq[k+1][l]   <= r_dq[k][l] | (32'(w_ge[l]) << SH);
                r_dneg[k+1][l] <= r_dneg[k][l];
                r_dovf[k+1][l] <= r_dovf[k][l];
            end
            r_dd[k+1]   <= r_dd[k];
            r_dpos[k+1] <= r_dpos[k];
            r_dang[k+1] <= r_dang[k];
        end
    end

    // stage 35: sign, saturation and zero-time handling of the rates
    logic        r_v3;
    logic [31:0] r_x3 [0:3];
    logic [31:0] w_vel [0:1];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_dd[32] == 24'd0) begin
                w_vel[l] = '0;
            end else if (r_dneg[32][l]) begin
                if (r_dovf[32][l] || (r_dq[32][l] > 32'h8000_0000)) begin
                    w_vel[l] = 32'h8000_0000;
                end else begin
                    w_vel[l] = 32'd0 - r_dq[32][l];
                end
            end else if (r_dovf[32][l] || r_dq[32][l][31]) begin
                w_vel[l] = 32'h7FFF_FFFF;
            end else begin
                w_vel[l] = r_dq[32][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_dv[32];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x3[0] <= r_dpos[32];
        r_x3[1] <= w_vel[0];
        r_x3[2] <= r_dang[32];
        r_x3[3] <= w_vel[1];
    end

    // stage 36: gain products
    logic               r_v4;
    logic signed [63:0] r_p4 [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_p4[i] <= 64'(r_gain[i]) * 64'($signed(r_x3[i]));
        end
    end

    // stage 37: floor shift, sum and negate
    logic               r_v5;
    logic signed [51:0] r_u5;
    logic signed [63:0] w_sum;

    always_comb begin
        w_sum = '0;
        for (int i = 0; i < 4; i++) begin
            w_sum = w_sum + (r_p4[i] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u5 <= 52'(64'sd0 - w_sum);
    end

    // stage 38: clamp, whole volts and duty numerator
    logic [51:0] w_mag;
    logic [51:0] w_vlim;
    logic        w_sat;
    logic [7:0]  w_volts;
    logic [4:0]  w_bits;
    logic [16:0] w_pow;
    logic [15:0] w_full;

    assign w_mag   = r_u5[51] ? (52'd0 - r_u5) : r_u5;
    assign w_vlim  = {44'd0, r_max_voltage} << FRAC_BITS;
    assign w_sat   = (w_mag >= w_vlim);
    assign w_volts = w_sat ? r_max_voltage : w_mag[FRAC_BITS +: 8];
    assign w_bits  = (r_duty_bits > 5'd16) ? 5'd16 : r_duty_bits;
    assign w_pow   = 17'd1 << w_bits;
    assign w_full  = 16'(w_pow - 17'd1);

    // duty divider arrays
    logic        r_yv    [0:16];
    logic [23:0] r_yn    [0:16];
    logic [15:0] r_yq    [0:16];
    logic [7:0]  r_yvm   [0:16];
    logic [15:0] r_yfull [0:16];
    logic        r_ydir  [0:16];
    logic        r_ysat  [0:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yv[0] <= 1'b0;
        end else begin
            r_yv[0] <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_yn[0]    <= {16'd0, w_volts} * {8'd0, w_full};
        r_yq[0]    <= '0;
        r_yvm[0]   <= r_max_voltage;
        r_yfull[0] <= w_full;
        r_ydir[0]  <= r_u5[51];
        r_ysat[0]  <= w_sat;
    end

    // duty divider: one quotient bit per stage, msb first
    for (genvar k = 0; k < 16; k++) begin : g_ddiv
        localparam int SH = 15 - k;
        logic [23:0] w_sub;
        logic        w_ge;

        assign w_sub = {16'd0, r_yvm[k]} << SH;
        assign w_ge  = (r_yn[k] >= w_sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_yv[k+1] <= 1'b0;
            end else begin
                r_yv[k+1] <= r_yv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_yn[k+1]    <= w_ge ? (r_yn[k] - w_sub) : r_yn[k];
            r_yq[k+1]    <= r_yq[k] | (16'(w_ge) << SH);
            r_yvm[k+1]   <= r_yvm[k];
            r_yfull[k+1] <= r_yfull[k];
            r_ydir[k+1]  <= r_ydir[k];
            r_ysat[k+1]  <= r_ysat[k];
        end
    end

    // output register, zero limit gives zero duty
    logic        r_out_v;
    t_out_item   r_out;
    logic [15:0] r_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_yv[16];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.pwm_duty  <= (r_yvm[16] == 8'd0) ? 16'd0 : r_yq[16];
        r_out.direction <= r_ydir[16];
        r_out.saturated <= r_ysat[16];
        r_out_full      <= r_yfull[16];
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

    // every result strobe comes from a matching earlier start
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LAT))
        else $error("result strobe without matching start");

    // duty never exceeds the full scale it was computed against
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.pwm_duty <= r_out_full))
        else $error("duty above full scale");

    // a saturated drive with a nonzero limit gives full scale
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_yv[16] && r_ysat[16] && (r_yvm[16] != 8'd0))
            |=> (o_result.pwm_duty == r_out_full))
        else $error("saturated drive not at full scale");

endmodule
